>>> hdl/mandelbrot_escape_count_top_macros.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape counter assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_COUNT_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_COUNT_TOP_MACROS_SVH

// same-cycle implication
`define MEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mec port check failed");

// next-cycle implication
`define MEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mec port check failed");

`endif

>>> hdl/mec_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape counter package
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned CNT_W   = 9;

  localparam logic [CNT_W-1:0] ITER_CAP   = 9'd256;
  localparam logic [CNT_W-1:0] ITER_RESET = 9'd256;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch point, clear z and count
    logic mul;     // register the three products of z
    logic step;    // take the new z, bump count
    logic finish;  // capture result word
    logic esc;     // result escaped flag
  } mec_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sq_esc;    // |z|^2 >= 4 from registered products
    logic mag_esc;   // a new part has magnitude >= 2
    logic at_limit;  // count reached the effective limit
  } mec_status_t;

endpackage

>>> hdl/mandelbrot_escape_count_top.sv
// busy is high while a point is processed; a new point may start in the done_o cycle.
// Each iteration is a registered product stage, then an add and escape check.
// Reset (async, active low) returns to idle and sets max_iterations to 256.
// ----------------------------------------------------------------------------
// Mandelbrot escape counter top level
// Counts z = z*z + c iterations until |z|^2 >= 4 or the configured limit.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count_top #(
  parameter int unsigned FRAC_BITS = 25
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mec_pkg::CNT_W-1:0]          cfg_wdata_i,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [mec_pkg::COORD_W-1:0] c_real_i,
  input  logic signed [mec_pkg::COORD_W-1:0] c_imag_i,
  output logic                               done_o,
  output logic [mec_pkg::CNT_W-1:0]          iteration_count_o,
  output logic                               escaped_o
);

  mec_pkg::mec_cmd_t    cmd;
  mec_pkg::mec_status_t status;

  mec_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  mec_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .c_real_i          (c_real_i),
    .c_imag_i          (c_imag_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .iteration_count_o (iteration_count_o),
    .escaped_o         (escaped_o)
  );

endmodule

>>> hdl/mec_ctrl.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape counter controller
// Sequences multiply and add/check phases of each iteration.
// ----------------------------------------------------------------------------
module mec_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mec_pkg::mec_status_t status_i,
  output mec_pkg::mec_cmd_t    cmd_o,
  output logic                busy_o,
  output logic                done_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        // escape check of the current z comes before the limit check
        if (status_i.sq_esc) begin
          cmd_o.finish = 1'b1;
          cmd_o.esc    = 1'b1;
          state_d      = ST_IDLE;
        end else if (status_i.at_limit) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          if (status_i.mag_esc) begin
            cmd_o.finish = 1'b1;
            cmd_o.esc    = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.finish;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

>>> hdl/mec_datapath.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape counter datapath
// z registers, product stage, update/escape logic, limit and result words.
// ----------------------------------------------------------------------------
module mec_datapath #(
  parameter int unsigned FRAC_BITS = 25
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mec_pkg::CNT_W-1:0]             cfg_wdata_i,
  input  logic signed [mec_pkg::COORD_W-1:0]    c_real_i,
  input  logic signed [mec_pkg::COORD_W-1:0]    c_imag_i,
  input  mec_pkg::mec_cmd_t                     cmd_i,
  output mec_pkg::mec_status_t                  status_o,
  output logic [mec_pkg::CNT_W-1:0]             iteration_count_o,
  output logic                                  escaped_o
);

  // z is only squared while each part has magnitude < 2, so it fits FRAC_BITS+2 bits
  localparam int unsigned ZSW = FRAC_BITS + 2;
  localparam int unsigned PW  = 2 * ZSW;
  localparam int unsigned SW  = PW + 1;
  localparam int unsigned NW0 = FRAC_BITS + 5;
  localparam int unsigned ZW  = ((NW0 > mec_pkg::COORD_W) ? NW0 : mec_pkg::COORD_W) + 1;

  typedef logic signed [ZSW-1:0] zs_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [SW-1:0]  sum_t;
  typedef logic signed [ZW-1:0]  zw_t;

  localparam sum_t FOUR_SQ = sum_t'(1) <<< (2 * FRAC_BITS + 2);
  localparam zw_t  TWO_P   = zw_t'(2) <<< FRAC_BITS;
  localparam zw_t  TWO_N   = -TWO_P;

  logic [mec_pkg::CNT_W-1:0]          max_iter_q;
  logic [mec_pkg::CNT_W-1:0]          limit_q, limit_d;
  logic [mec_pkg::CNT_W-1:0]          count_q, count_inc;
  logic signed [mec_pkg::COORD_W-1:0] cr_q, ci_q;
  zs_t                                zr_q, zi_q;
  prod_t                              rr_q, ii_q, ri_q;
  prod_t                              rr_d, ii_d, ri_d;
  sum_t                               sq_sum, diff, twice_ri;
  zw_t                                nr, ni;
  logic [mec_pkg::CNT_W-1:0]          res_count_q;
  logic                               res_esc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= mec_pkg::ITER_RESET;
    end else if (cfg_we_i) begin
      max_iter_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, anything above the cap saturates
  always_comb begin
    if (max_iter_q == '0) begin
      limit_d = mec_pkg::CNT_W'(1);
    end else if (max_iter_q > mec_pkg::ITER_CAP) begin
      limit_d = mec_pkg::ITER_CAP;
    end else begin
      limit_d = max_iter_q;
    end
  end

  assign rr_d = zr_q * zr_q;
  assign ii_d = zi_q * zi_q;
  assign ri_d = zr_q * zi_q;

  assign sq_sum   = sum_t'(rr_q) + sum_t'(ii_q);
  assign diff     = sum_t'(rr_q) - sum_t'(ii_q);
  assign twice_ri = sum_t'(ri_q) <<< 1;

  // arithmetic shift gives floor division
  assign nr = zw_t'(diff >>> FRAC_BITS) + zw_t'(cr_q);
  assign ni = zw_t'(twice_ri >>> FRAC_BITS) + zw_t'(ci_q);

  assign count_inc = count_q + mec_pkg::CNT_W'(1);

  assign status_o.sq_esc   = (sq_sum >= FOUR_SQ);
  assign status_o.mag_esc  = !((nr < TWO_P) && (nr > TWO_N)) ||
                             !((ni < TWO_P) && (ni > TWO_N));
  assign status_o.at_limit = (count_q == limit_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cr_q    <= c_real_i;
      ci_q    <= c_imag_i;
      zr_q    <= '0;
      zi_q    <= '0;
      count_q <= '0;
      limit_q <= limit_d;
    end
    if (cmd_i.mul) begin
      rr_q <= rr_d;
      ii_q <= ii_d;
      ri_q <= ri_d;
    end
    if (cmd_i.step) begin
      zr_q    <= nr[ZSW-1:0];
      zi_q    <= ni[ZSW-1:0];
      count_q <= count_inc;
    end
    if (cmd_i.finish) begin
      res_count_q <= cmd_i.step ? count_inc : count_q;
      res_esc_q   <= cmd_i.esc;
    end
  end

  assign iteration_count_o = res_count_q;
  assign escaped_o         = res_esc_q;

endmodule

>>> hdl/mec_checker.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape counter port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_count_top_macros.svh"

module mec_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic [mec_pkg::CNT_W-1:0] iteration_count_o
);

  logic count_ok;

  assign count_ok = (iteration_count_o >= 9'd1) &&
                    (iteration_count_o <= mec_pkg::ITER_CAP);

  // an accepted point always occupies the block
  `MEC_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)

  // result word only appears once the block is idle again
  `MEC_ASSERT_IMPLY(a_done_idle, clk_i, rst_ni, done_o, !busy)

  // every point passes through MUL and ADD before it can finish, so done is a lone strobe
  `MEC_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

  `MEC_ASSERT_IMPLY(a_count_range, clk_i, rst_ni, done_o, count_ok)

endmodule

bind mandelbrot_escape_count_top mec_checker u_mec_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .done_o            (done_o),
  .iteration_count_o (iteration_count_o)
);

>>> test/mandelbrot_escape_count_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mandelbrot escape counter testbench
// Sends complex points and limit writes to the counter, predicts the
// iteration count and escape flag of every point in fixed point, and checks
// each result word in order.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count_top_tb;

  localparam int unsigned FRAC        = 25;
  localparam int unsigned GAP_MAX     = 18;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PER_PHASE   = 128;

  typedef enum logic [1:0] {K_POINT, K_LIMIT, K_DRAIN} word_kind_e;
  typedef enum logic [2:0] {ST_FETCH, ST_GAP, ST_SEND, ST_SETTLE, ST_END} drv_state_e;

  typedef struct packed {
    word_kind_e                         kind;
    logic signed [mec_pkg::COORD_W-1:0] c_real;
    logic signed [mec_pkg::COORD_W-1:0] c_imag;
    logic [4:0]                         gap;
    logic [mec_pkg::CNT_W-1:0]          limit;
  } stim_word_t;

  typedef struct packed {
    logic [mec_pkg::CNT_W-1:0] count;
    logic                      escaped;
  } escape_t;

  localparam logic signed [mec_pkg::COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [mec_pkg::COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [mec_pkg::COORD_W-1:0] ONE   = 32'sd1 <<< FRAC;

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               cfg_we_i    = 1'b0;
  logic [mec_pkg::CNT_W-1:0]          cfg_wdata_i = '0;
  logic                               start       = 1'b0;
  logic                               busy;
  logic signed [mec_pkg::COORD_W-1:0] c_real_i    = '0;
  logic signed [mec_pkg::COORD_W-1:0] c_imag_i    = '0;
  logic                               done_o;
  logic [mec_pkg::CNT_W-1:0]          iteration_count_o;
  logic                               escaped_o;

  stim_word_t pending_words[$];
  escape_t    expected_results[$];

  // driver shadows: each DUT input gets one nonblocking write per edge
  logic                               nxt_start = 1'b0;
  logic                               nxt_we    = 1'b0;
  logic [mec_pkg::CNT_W-1:0]          nxt_wdata = '0;
  logic signed [mec_pkg::COORD_W-1:0] nxt_real  = '0;
  logic signed [mec_pkg::COORD_W-1:0] nxt_imag  = '0;

  drv_state_e                drv_state = ST_FETCH;
  stim_word_t                cur;
  int unsigned               gap_left, settle_left;
  logic [mec_pkg::CNT_W-1:0] limit_now = mec_pkg::ITER_RESET;
  bit                        all_sent  = 1'b0;

  escape_t     want;
  int unsigned errors, points_sent, limits_written, n_escaped, n_inside, quiet;

  mandelbrot_escape_count_top #(.FRAC_BITS(FRAC)) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start             (start),
    .busy              (busy),
    .c_real_i          (c_real_i),
    .c_imag_i          (c_imag_i),
    .done_o            (done_o),
    .iteration_count_o (iteration_count_o),
    .escaped_o         (escaped_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // z <= z*z + c with floored shifts; stop on |z|^2 >= 4 or at the limit
  function automatic escape_t escape_time(input logic signed [mec_pkg::COORD_W-1:0] cr,
                                          input logic signed [mec_pkg::COORD_W-1:0] ci,
                                          input logic [mec_pkg::CNT_W-1:0] lim);
    longint      zr, zi, nr, ni, two, four_sq;
    int unsigned cap, n;
    bit          esc;
    escape_t     r;
    two     = longint'(2) <<< FRAC;
    four_sq = longint'(4) <<< (2 * FRAC);
    cap = lim;
    if (cap == 0) cap = 1;
    if (cap > mec_pkg::ITER_CAP) cap = mec_pkg::ITER_CAP;
    zr  = 0;
    zi  = 0;
    n   = 0;
    esc = 1'b0;
    do begin
      nr = ((zr * zr - zi * zi) >>> FRAC) + longint'(cr);
      ni = ((2 * zr * zi) >>> FRAC) + longint'(ci);
      zr = nr;
      zi = ni;
      n++;
      // large parts are never squared
      if ((zr < 0 ? -zr : zr) >= two || (zi < 0 ? -zi : zi) >= two) esc = 1'b1;
      else if (zr * zr + zi * zi >= four_sq) esc = 1'b1;
    end while (!esc && n < cap);
    r.count   = n[mec_pkg::CNT_W-1:0];
    r.escaped = esc;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("%0t mismatch %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    errors++;
  endtask

  task automatic push_point(input logic signed [mec_pkg::COORD_W-1:0] cr,
                            input logic signed [mec_pkg::COORD_W-1:0] ci,
                            input int unsigned gap);
    stim_word_t w;
    w        = '0;
    w.kind   = K_POINT;
    w.c_real = cr;
    w.c_imag = ci;
    w.gap    = gap[4:0];
    pending_words.push_back(w);
  endtask

  // limit write (or a plain drain) waits until every result is back
  task automatic push_limit(input word_kind_e kind, input logic [mec_pkg::CNT_W-1:0] lim);
    stim_word_t w;
    w       = '0;
    w.kind  = kind;
    w.limit = lim;
    pending_words.push_back(w);
  endtask

  function automatic int unsigned rgap();
    return $urandom_range(0, GAP_MAX);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_results.push_back(escape_time(c_real_i, c_imag_i, limit_now));
        points_sent++;
        nxt_start = 1'b0;
        drv_state = ST_FETCH;
      end
      nxt_we = 1'b0;
      if (drv_state == ST_FETCH) begin
        if (pending_words.size() == 0) begin
          all_sent  = 1'b1;
          drv_state = ST_END;
        end else begin
          cur         = pending_words.pop_front();
          gap_left    = cur.gap;
          settle_left = SETTLE;
          drv_state   = (cur.kind == K_POINT) ? ST_GAP : ST_SETTLE;
        end
      end
      if (drv_state == ST_GAP) begin
        if (gap_left == 0) begin
          nxt_start = 1'b1;
          nxt_real  = cur.c_real;
          nxt_imag  = cur.c_imag;
          drv_state = ST_SEND;
        end else begin
          gap_left--;
        end
      end
      if (drv_state == ST_SETTLE) begin
        if (expected_results.size() != 0 || busy || done_o) begin
          settle_left = SETTLE;
        end else if (settle_left != 0) begin
          settle_left--;
        end else begin
          if (cur.kind == K_LIMIT) begin
            nxt_we    = 1'b1;
            nxt_wdata = cur.limit;
            limit_now = cur.limit;
            limits_written++;
          end
          drv_state = ST_FETCH;
        end
      end
    end
    start       <= nxt_start;
    c_real_i    <= nxt_real;
    c_imag_i    <= nxt_imag;
    cfg_we_i    <= nxt_we;
    cfg_wdata_i <= nxt_wdata;
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with no point pending", 0, iteration_count_o);
      end else begin
        want = expected_results.pop_front();
        if (iteration_count_o !== want.count)
          report_mismatch("iteration_count", want.count, iteration_count_o);
        if (escaped_o !== want.escaped)
          report_mismatch("escaped", want.escaped, escaped_o);
        if (want.escaped) n_escaped++;
        else n_inside++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || cfg_we_i) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t watchdog: no activity for %0d cycles", $time, quiet);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [mec_pkg::CNT_W-1:0]          lim;
    logic signed [mec_pkg::COORD_W-1:0] cr, ci;
    int unsigned                        sel;
    bit                                 no_gaps;

    // reset limit of 256 first, no write
    push_point(0, 0, rgap());
    push_point(C_MAX, 0, 0);
    push_point(C_MIN, 0, 0);
    push_point(0, C_MAX, rgap());
    push_point(0, C_MIN, 0);
    push_point(C_MIN, C_MIN, rgap());
    push_point(C_MAX, C_MAX, 0);
    push_point(C_MAX, C_MIN, 0);
    push_point(-2 * ONE, 0, rgap());
    push_point(-2 * ONE + 1, 0, rgap());
    push_point(ONE / 4, 0, 0);
    push_point(ONE / 4 + (ONE >>> 7), 0, rgap());
    push_point(-ONE, 0, 0);
    push_point(0, ONE, rgap());
    push_point(ONE, 0, 0);
    // inside the box of side 4 but |c|^2 > 4: escapes on the square test
    push_point(3 * ONE / 2, 3 * ONE / 2, rgap());
    push_point(0, -2 * ONE, 0);
    push_limit(K_DRAIN, 0);
    push_limit(K_LIMIT, 9'd1);
    push_point(ONE, 0, rgap());
    push_point(3 * ONE / 2, 3 * ONE / 2, 0);
    push_limit(K_LIMIT, 9'd2);
    // escapes exactly at the limit
    push_point(ONE, 0, 0);
    push_point(0, 0, rgap());
    push_limit(K_LIMIT, 9'd0);
    push_point(0, 0, 0);
    push_limit(K_LIMIT, 9'd511);
    push_point(0, 0, rgap());
    push_limit(K_LIMIT, 9'd257);
    push_point(-ONE, ONE / 8, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: lim = $urandom_range(0, 511);
        1: lim = $urandom_range(1, 8);
        2: lim = $urandom_range(9, 64);
        default: lim = $urandom_range(65, 255);
      endcase
      push_limit(K_LIMIT, lim);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PER_PHASE; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
          cr = $urandom();
          ci = $urandom();
        end else if (sel < 35) begin
          // close to the boundary near the main bulb neck
          cr = -(3 * ONE / 4) + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
          ci = (ONE / 10) + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        end else begin
          cr = $signed($urandom_range(0, 3 * ONE)) - (9 * ONE / 4);
          ci = $signed($urandom_range(0, 3 * ONE)) - (3 * ONE / 2);
        end
        push_point(cr, ci, no_gaps ? 0 : rgap());
        if ($urandom_range(0, 199) == 0) push_limit(K_DRAIN, 0);
      end
    end
    push_limit(K_LIMIT, mec_pkg::ITER_RESET);
    push_point(ONE / 4, ONE / 2, rgap());

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (!all_sent || expected_results.size() != 0);
    repeat (40) @(posedge clk_i);

    $display("checked %0d points across %0d limit writes plus the reset limit",
             points_sent, limits_written);
    $display("%0d points escaped, %0d ran to their limit", n_escaped, n_inside);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
